### rtl/core/slcfd_pkg.sv
// ----------------------------------------------------------------------------
// slcfd_pkg
// Shared types, constants and the bytewise CRC-16/Modbus update for the
// sync/length/CRC frame decoder.
// ----------------------------------------------------------------------------
package slcfd_pkg;

  // largest whole frame in bytes (length field plus six overhead bytes)
  localparam int unsigned MAX_FRAME_BYTES = 1024;

  localparam int unsigned CountW = 11;
  localparam int unsigned LenW   = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0]       SYNC_WORD_RESET = 16'hAA55;
  localparam logic [CountW-1:0] FRAME_CAP_RESET = CountW'(MAX_FRAME_BYTES);

  // frame bytes besides the payload: sync, length and crc
  localparam logic [LenW:0] FRAME_OVERHEAD = 17'd6;

  // configuration register indexes
  typedef enum logic {
    CFG_SYNC_WORD = 1'b0,
    CFG_FRAME_CAP = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_HUNTING    = 3'd0,
    ST_OUT_OF_SYNC = 3'd1,
    ST_LENGTH     = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_PAYLOAD    = 3'd4,
    ST_CRC_BYTE   = 3'd5,
    ST_GOOD_FRAME = 3'd6,
    ST_CRC_ERROR  = 3'd7
  } status_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic [7:0]          data_byte;
    logic                payload_valid;
    logic [CountW-1:0]   byte_count;
    logic [LenW-1:0]     frame_length;
  } result_t;

  // reflected crc-16 update over one byte, eight narrow shift steps
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/slcfd_decode.sv
// ----------------------------------------------------------------------------
// slcfd_decode
// Frame state machine: sync hunt, length, payload and crc phases, with the
// running crc. Produces the result for the byte at its input.
// ----------------------------------------------------------------------------
module slcfd_decode (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [7:0]                       rx_byte,
  input  logic [15:0]                      sync_word,
  input  logic [slcfd_pkg::CountW-1:0]     frame_capacity,
  output slcfd_pkg::result_t               result
);
  import slcfd_pkg::*;

  phase_t            phase, phase_next;
  logic [7:0]        window_byte, window_byte_next;
  logic [15:0]       window_crc, window_crc_next;
  logic [CountW-1:0] position, position_next;
  logic [LenW-1:0]   payload_length, payload_length_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [7:0]        crc_high_byte, crc_high_byte_next;

  logic [CountW-1:0] cap;
  logic [CountW-1:0] pos_inc;
  logic [LenW-1:0]   len_low;
  logic [15:0]       crc_step;
  logic              do_restart;
  status_t           status;
  logic              pv;
  logic [CountW-1:0] count;
  logic [LenW-1:0]   flen;

  // capacity clamped to the hard frame limit
  assign cap = (frame_capacity > CountW'(MAX_FRAME_BYTES)) ?
               CountW'(MAX_FRAME_BYTES) : frame_capacity;

  assign pos_inc  = position + 1'b1;
  assign len_low  = {payload_length[15:8], rx_byte};
  assign crc_step = crc16_byte(running_crc, rx_byte);

  // next state and result
  always_comb begin
    phase_next          = phase;
    window_byte_next    = window_byte;
    window_crc_next     = window_crc;
    position_next       = position;
    payload_length_next = payload_length;
    running_crc_next    = running_crc;
    crc_high_byte_next  = crc_high_byte;
    status              = ST_HUNTING;
    pv                  = 1'b0;
    do_restart          = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (position != CountW'(1)) begin
          window_byte_next = rx_byte;
          window_crc_next  = crc16_byte(CRC_INIT, rx_byte);
          position_next    = CountW'(1);
        end else if ({window_byte, rx_byte} == sync_word) begin
          running_crc_next = crc16_byte(window_crc, rx_byte);
          position_next    = CountW'(2);
          phase_next       = PH_LEN;
        end else begin
          window_byte_next = rx_byte;
          window_crc_next  = crc16_byte(CRC_INIT, rx_byte);
          position_next    = CountW'(1);
          status           = ST_OUT_OF_SYNC;
        end
      end
      PH_LEN: begin
        running_crc_next = crc_step;
        status           = ST_LENGTH;
        if (position == CountW'(2)) begin
          payload_length_next = {rx_byte, 8'h00};
          position_next       = CountW'(3);
        end else begin
          payload_length_next = len_low;
          position_next       = CountW'(4);
          if (({1'b0, len_low} + FRAME_OVERHEAD) > {6'b0, cap}) begin
            status     = ST_TOO_LARGE;
            do_restart = 1'b1;
          end else if (len_low == '0) begin
            phase_next = PH_CRC;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        running_crc_next = crc_step;
        position_next    = pos_inc;
        status           = ST_PAYLOAD;
        pv               = 1'b1;
        if (({6'b0, pos_inc} - 17'd4) >= {1'b0, payload_length}) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        position_next = pos_inc;
        if ({6'b0, pos_inc} == ({1'b0, payload_length} + 17'd5)) begin
          crc_high_byte_next = rx_byte;
          status             = ST_CRC_BYTE;
        end else begin
          status     = ({crc_high_byte, rx_byte} == running_crc) ?
                       ST_GOOD_FRAME : ST_CRC_ERROR;
          do_restart = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    // result fields are taken before any restart
    count = position_next;
    flen  = payload_length_next;

    if (do_restart) begin
      phase_next          = PH_HUNT;
      window_byte_next    = '0;
      window_crc_next     = crc16_byte(CRC_INIT, 8'h00);
      position_next       = '0;
      payload_length_next = '0;
      running_crc_next    = CRC_INIT;
      crc_high_byte_next  = '0;
    end
  end

  assign result.status        = status;
  assign result.data_byte     = rx_byte;
  assign result.payload_valid = pv;
  assign result.byte_count    = count;
  assign result.frame_length  = flen;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      window_byte    <= '0;
      window_crc     <= crc16_byte(CRC_INIT, 8'h00);
      position       <= '0;
      payload_length <= '0;
      running_crc    <= CRC_INIT;
      crc_high_byte  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      window_byte    <= window_byte_next;
      window_crc     <= window_crc_next;
      position       <= position_next;
      payload_length <= payload_length_next;
      running_crc    <= running_crc_next;
      crc_high_byte  <= crc_high_byte_next;
    end
  end

endmodule

### rtl/core/slcfd_out_reg.sv
// ----------------------------------------------------------------------------
// slcfd_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module slcfd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  slcfd_pkg::result_t  result_in,
  input  logic                stall,
  output logic                valid,
  output slcfd_pkg::result_t  result_out
);
  import slcfd_pkg::*;

  result_t held;

  // valid flag: set on load, cleared once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result_in;
    end
  end

  assign result_out = held;

endmodule

### rtl/core/sync_length_crc_frame_decoder.sv
// ----------------------------------------------------------------------------
// sync_length_crc_frame_decoder
// Hunts a two-byte sync word, reads a big-endian length, passes the payload
// through and checks a trailing CRC-16/Modbus; one status item per byte.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   byte      byte_valid / byte_stall    rx_byte
//   result    result_valid / result_stall status, data_byte, payload_valid,
//                                          byte_count, frame_length
//   config    cfg_we                     cfg_index, cfg_data
//
// One byte per cycle while byte_stall is low; a result appears in the cycle after its byte is taken.
// The bytewise crc update and the phase logic sit between the input port and
// the result register, so the result register alone sets the latency.
// Reset (rst, synchronous) returns to the sync hunt with default registers.
// A stalled result stalls the input only when no slot frees that cycle.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    status,
  output logic [7:0]                    data_byte,
  output logic                          payload_valid,
  output logic [slcfd_pkg::CountW-1:0]  byte_count,
  output logic [slcfd_pkg::LenW-1:0]    frame_length,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);
  import slcfd_pkg::*;

  logic [15:0]       sync_word;
  logic [CountW-1:0] frame_capacity;
  logic              accept;
  result_t           res_comb;
  result_t           res_reg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= SYNC_WORD_RESET;
      frame_capacity <= FRAME_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SYNC_WORD: sync_word      <= cfg_data;
        CFG_FRAME_CAP: frame_capacity <= cfg_data[CountW-1:0];
        default:       sync_word      <= sync_word;
      endcase
    end
  end

  // input handshake
  assign byte_stall = result_valid & result_stall;
  assign accept     = byte_valid & ~byte_stall;

  slcfd_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rx_byte        (rx_byte),
    .sync_word      (sync_word),
    .frame_capacity (frame_capacity),
    .result         (res_comb)
  );

  slcfd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (res_comb),
    .stall      (result_stall),
    .valid      (result_valid),
    .result_out (res_reg)
  );

  assign status        = res_reg.status;
  assign data_byte     = res_reg.data_byte;
  assign payload_valid = res_reg.payload_valid;
  assign byte_count    = res_reg.byte_count;
  assign frame_length  = res_reg.frame_length;

  // payload bytes are only flagged in the payload status
  a_pv_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && payload_valid |-> status == ST_PAYLOAD)
    else $error("payload_valid outside payload status");

  // frame end reports the whole frame length as the count
  a_end_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_GOOD_FRAME || status == ST_CRC_ERROR) |->
      {5'b0, byte_count} == frame_length + 16'd6)
    else $error("frame end count mismatch");

  // rejected length is reported after the four header bytes
  a_too_large: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_TOO_LARGE |-> byte_count == CountW'(4))
    else $error("too_large count mismatch");

  // an accepted byte always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |=> result_valid)
    else $error("accepted byte gave no result");

endmodule
